// File: rtl/core/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg
// Types, constants and helpers shared by the beacon parent tracker modules.
// ----------------------------------------------------------------------------
package bpt_pkg;

	// list depth default
	localparam int MAX_CANDIDATES = 8;

	// beacon byte positions
	localparam logic [7:0] POS_PARENT = 8'd2;
	localparam logic [7:0] POS_ALT    = 8'd6;
	localparam logic [7:0] POS_LAYER  = 8'd8;
	localparam logic [7:0] POS_COUNT  = 8'd10;
	localparam logic [7:0] POS_CAND   = 8'd11;
	localparam logic [7:0] POS_MAX    = 8'd255;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_OWN_ID   = 2'd0,
		REG_HEADER   = 2'd1,
		REG_OFFSET   = 2'd2,
		REG_OVERHEAR = 2'd3
	} reg_idx_t;

	// input item
	typedef struct packed {
		logic [7:0] payload_byte;
		logic [7:0] sender_id;
		logic [7:0] routing_parent_id;
		logic       last_byte;
	} in_item_t;

	// result item
	typedef struct packed {
		logic       kind;
		logic [7:0] link_node;
		logic [7:0] link_peer;
		logic [7:0] parent_out;
		logic [7:0] grandparent_out;
		logic [7:0] alternate_out;
		logic [7:0] layer_out;
		logic       final_res;
	} out_item_t;

	// decoded beacon view handed from capture to tracker
	typedef struct packed {
		logic       fire;
		logic       finish;
		logic [7:0] sid;
		logic [7:0] mp;
		logic [7:0] pid;
		logic [7:0] aid;
		logic [7:0] layer;
	} beacon_t;

	// everything the result buffer loads on a last byte
	typedef struct packed {
		logic [3:0]       links;
		logic [3:0][7:0]  peers;
		logic [7:0]       node;
		logic [7:0]       parent;
		logic [7:0]       grandparent;
		logic [7:0]       alternate;
		logic [7:0]       layer;
	} res_load_t;

	// remove the field offset, modulo 256
	function automatic logic [7:0] decode_byte(input logic [7:0] b, input logic [7:0] off);
		decode_byte = b - off;
	endfunction

endpackage

// File: rtl/core/beacon_parent_tracker_unit.sv
// ----------------------------------------------------------------------------
// beacon_parent_tracker_unit
// Tracks parent, grandparent, alternate parent and layer from neighbor
// beacons received one byte per item; emits link requests and a status.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; a last byte is held while the previous last
// byte is in the input register or its one to five results drain, one per
// cycle while out_ready is high. A last byte's results pass the input register,
// then the result buffer, before they are offered.
// Reset: asynchronous, clears tracked state, byte position and buffer;
// configuration returns to own id 1, header 0, offset 0, overhearing on.
module beacon_parent_tracker_unit import bpt_pkg::*; #(
	parameter int MAX_CAND = MAX_CANDIDATES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] own_id_q;
	logic [7:0] header_q;
	logic [7:0] offset_q;
	logic       ovh_q;
	logic       cfg_wr;
	reg_idx_t   reg_idx;

	logic                     in_take;
	logic                     s1_last;
	logic                     res_empty;
	beacon_t                  bcn;
	logic [MAX_CAND-1:0][7:0] cand_view;
	logic [MAX_CAND-1:0]      cand_mask;
	res_load_t                ld;

	// configuration registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= 8'd1;
			header_q <= 8'd0;
			offset_q <= 8'd0;
			ovh_q    <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_OWN_ID:   own_id_q <= pwdata[7:0];
				REG_HEADER:   header_q <= pwdata[7:0];
				REG_OFFSET:   offset_q <= pwdata[7:0];
				REG_OVERHEAR: ovh_q    <= pwdata[0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_OWN_ID:   prdata = 32'(own_id_q);
			REG_HEADER:   prdata = 32'(header_q);
			REG_OFFSET:   prdata = 32'(offset_q);
			REG_OVERHEAR: prdata = 32'(ovh_q);
			default:      prdata = '0;
		endcase
	end

	// a last byte needs an empty result buffer when it reaches the update
	assign in_ready = !in_item.last_byte || (res_empty && !s1_last);
	assign in_take  = in_valid && in_ready;

	bpt_capture #(
		.MAX_CAND (MAX_CAND)
	) u_capture (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_take      (in_take),
		.in_item      (in_item),
		.header_byte  (header_q),
		.field_offset (offset_q),
		.bcn          (bcn),
		.cand_view    (cand_view),
		.cand_mask    (cand_mask),
		.s1_last      (s1_last)
	);

	bpt_tracker #(
		.MAX_CAND (MAX_CAND)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.bcn          (bcn),
		.cand_view    (cand_view),
		.cand_mask    (cand_mask),
		.own_node_id  (own_id_q),
		.field_offset (offset_q),
		.overhear_en  (ovh_q),
		.ld           (ld)
	);

	bpt_results u_results (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (bcn.fire),
		.ld        (ld),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item),
		.empty     (res_empty)
	);

	// a last byte in the input stage never meets pending results
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s1_last |-> res_empty)
		else $error("last byte reached update with results pending");

	// every last byte leaves results to deliver
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s1_last |=> out_valid)
		else $error("no result after last byte");

	// the status item is the only final item
	a_final_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.kind == out_item.final_res))
		else $error("final flag disagrees with result kind");

endmodule

// File: rtl/core/bpt_capture.sv
// ----------------------------------------------------------------------------
// bpt_capture
// Input register, byte position counter and capture of beacon fields and
// raw candidate ids, with forwarding of the byte held in the input stage.
// ----------------------------------------------------------------------------
module bpt_capture import bpt_pkg::*; #(
	parameter int MAX_CAND = MAX_CANDIDATES
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_take,
	input  in_item_t                 in_item,
	input  logic [7:0]               header_byte,
	input  logic [7:0]               field_offset,
	output beacon_t                  bcn,
	output logic [MAX_CAND-1:0][7:0] cand_view,
	output logic [MAX_CAND-1:0]      cand_mask,
	output logic                     s1_last
);

	logic                     valid_s1;
	in_item_t                 item_s1;
	logic [7:0]               pos_q;
	logic                     header_ok_q;
	logic [7:0]               sid_q;
	logic [7:0]               mp_q;
	logic [7:0]               pid_q;
	logic [7:0]               aid_q;
	logic [7:0]               layer_q;
	logic [7:0]               count_q;
	logic [MAX_CAND-1:0][7:0] cand_q;

	logic [7:0] dec;
	logic [7:0] cand_off;
	logic       cand_wr;
	logic [7:0] count_eff;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_item;
		end
	end

	// byte decode and candidate slot
	always_comb begin
		dec       = decode_byte(item_s1.payload_byte, field_offset);
		cand_off  = pos_q - POS_CAND;
		cand_wr   = valid_s1 && (pos_q >= POS_CAND) && (cand_off < 8'(MAX_CAND));
		count_eff = (pos_q == POS_COUNT) ? dec : count_q;
	end

	// position counter, header check, sampled ids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			header_ok_q <= 1'b0;
			sid_q       <= '0;
			mp_q        <= '0;
		end else if (valid_s1) begin
			if (pos_q == '0) begin
				header_ok_q <= (item_s1.payload_byte == header_byte);
				sid_q       <= item_s1.sender_id;
				mp_q        <= item_s1.routing_parent_id;
			end
			if (item_s1.last_byte) begin
				pos_q <= '0;
			end else if (pos_q != POS_MAX) begin
				pos_q <= pos_q + 8'd1;
			end
		end
	end

	// decoded beacon fields
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			if (pos_q == POS_PARENT) begin
				pid_q <= dec;
			end
			if (pos_q == POS_ALT) begin
				aid_q <= dec;
			end
			if (pos_q == POS_LAYER) begin
				layer_q <= dec;
			end
			if (pos_q == POS_COUNT) begin
				count_q <= dec;
			end
		end
	end

	// candidate slots, with the byte in the stage forwarded
	for (genvar k = 0; k < MAX_CAND; k++) begin : g_cand
		always_ff @(posedge clk) begin
			if (cand_wr && (cand_off == 8'(k))) begin
				cand_q[k] <= item_s1.payload_byte;
			end
		end

		assign cand_view[k] = (cand_wr && (cand_off == 8'(k))) ? item_s1.payload_byte
			: cand_q[k];
		// slot counts when below the decoded count and actually received
		assign cand_mask[k] = (8'(k) < count_eff) && (8'(k + 11) <= pos_q);
	end

	// beacon view for the tracker
	always_comb begin
		bcn.fire   = valid_s1 && item_s1.last_byte;
		bcn.finish = valid_s1 && item_s1.last_byte && header_ok_q && (pos_q >= POS_COUNT);
		bcn.sid    = sid_q;
		bcn.mp     = mp_q;
		bcn.pid    = pid_q;
		bcn.aid    = aid_q;
		bcn.layer  = layer_q;
	end

	assign s1_last = valid_s1 && item_s1.last_byte;

endmodule

// File: rtl/core/bpt_tracker.sv
// ----------------------------------------------------------------------------
// bpt_tracker
// Parent, grandparent, alternate and layer registers and the end-of-beacon
// update, including overhearing link request selection.
// ----------------------------------------------------------------------------
module bpt_tracker import bpt_pkg::*; #(
	parameter int MAX_CAND = MAX_CANDIDATES
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  beacon_t                  bcn,
	input  logic [MAX_CAND-1:0][7:0] cand_view,
	input  logic [MAX_CAND-1:0]      cand_mask,
	input  logic [7:0]               own_node_id,
	input  logic [7:0]               field_offset,
	input  logic                     overhear_en,
	output res_load_t                ld
);

	logic [7:0] parent_q;
	logic [7:0] gp_q;
	logic [7:0] alt_q;
	logic [7:0] layer_q;

	logic                par_chg;
	logic [7:0]          gp1;
	logic [7:0]          alt1;
	logic [7:0]          gp2;
	logic [7:0]          alt2;
	logic [7:0]          nl;
	logic [7:0]          layer2;
	logic                c1;
	logic                c2;
	logic                sib;
	logic [MAX_CAND-1:0] gp_hit;
	logic [MAX_CAND-1:0] par_hit;
	logic [3:0]          links;

	// candidate compares against the updated grandparent and parent
	for (genvar k = 0; k < MAX_CAND; k++) begin : g_hit
		assign gp_hit[k]  = cand_mask[k]
			&& (decode_byte(cand_view[k], field_offset) == gp2);
		assign par_hit[k] = cand_mask[k]
			&& (decode_byte(cand_view[k], field_offset) == bcn.mp);
	end

	// parent change, grandparent and alternate
	always_comb begin
		par_chg = (parent_q != bcn.mp);
		gp1     = par_chg ? 8'd0 : gp_q;
		alt1    = (par_chg && (alt_q != 8'd0) && (alt_q == bcn.mp)) ? parent_q : alt_q;
		gp2     = ((bcn.sid == bcn.mp) && (bcn.pid != 8'd0)) ? bcn.pid : gp1;
		alt2    = alt1;
		if ((bcn.mp != bcn.sid)
			&& (((gp2 != 8'd0) && (bcn.pid != 8'd0) && (gp2 == bcn.pid)) || (|gp_hit))) begin
			alt2 = bcn.sid;
		end
	end

	// layer and link requests
	always_comb begin
		c1     = (bcn.pid != 8'd0) && (own_node_id == bcn.pid);
		c2     = (bcn.aid != 8'd0) && (own_node_id == bcn.aid);
		nl     = (bcn.layer == 8'd255) ? 8'd255 : bcn.layer + 8'd1;
		layer2 = layer_q;
		if ((c1 || c2) && (bcn.layer != 8'd0) && ((layer_q == 8'd0) || (layer_q > nl))) begin
			layer2 = nl;
		end
		sib      = (bcn.pid != 8'd0) && ((bcn.pid == bcn.mp) || (|par_hit));
		links[0] = c1 && overhear_en && (bcn.aid != 8'd0);
		links[1] = c2 && overhear_en;
		links[2] = sib && overhear_en;
		links[3] = sib && overhear_en && (bcn.aid != 8'd0);
	end

	// load for the result buffer
	always_comb begin
		ld.links    = bcn.finish ? links : 4'd0;
		ld.peers[0] = bcn.aid;
		ld.peers[1] = bcn.pid;
		ld.peers[2] = bcn.pid;
		ld.peers[3] = bcn.aid;
		ld.node     = bcn.sid;
		if (bcn.finish) begin
			ld.parent      = bcn.mp;
			ld.grandparent = gp2;
			ld.alternate   = alt2;
			ld.layer       = layer2;
		end else begin
			ld.parent      = parent_q;
			ld.grandparent = gp_q;
			ld.alternate   = alt_q;
			ld.layer       = layer_q;
		end
	end

	// tracked state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parent_q <= '0;
			gp_q     <= '0;
			alt_q    <= '0;
			layer_q  <= '0;
		end else if (bcn.finish) begin
			parent_q <= bcn.mp;
			gp_q     <= gp2;
			alt_q    <= alt2;
			layer_q  <= layer2;
		end
	end

endmodule

// File: rtl/core/bpt_results.sv
// ----------------------------------------------------------------------------
// bpt_results
// Result buffer for one beacon: up to four link requests and the status,
// delivered lowest slot first, one item per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module bpt_results import bpt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  res_load_t ld,
	input  logic      out_ready,
	output logic      out_valid,
	output out_item_t out_item,
	output logic      empty
);

	logic [4:0] pend_q;
	res_load_t  data_q;
	logic [4:0] sel;
	logic [7:0] peer;

	// pending slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (fire) begin
			pend_q <= {1'b1, ld.links};
		end else if (out_valid && out_ready) begin
			pend_q <= pend_q & (pend_q - 5'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			data_q <= ld;
		end
	end

	// lowest pending slot
	always_comb begin
		sel  = pend_q & (~pend_q + 5'd1);
		peer = '0;
		for (int k = 0; k < 4; k++) begin
			if (sel[k]) begin
				peer = data_q.peers[k];
			end
		end
	end

	// result item
	always_comb begin
		out_item.kind            = sel[4];
		out_item.link_node       = sel[4] ? 8'd0 : data_q.node;
		out_item.link_peer       = sel[4] ? 8'd0 : peer;
		out_item.parent_out      = sel[4] ? data_q.parent : 8'd0;
		out_item.grandparent_out = sel[4] ? data_q.grandparent : 8'd0;
		out_item.alternate_out   = sel[4] ? data_q.alternate : 8'd0;
		out_item.layer_out       = sel[4] ? data_q.layer : 8'd0;
		out_item.final_res       = sel[4];
	end

	assign out_valid = |pend_q;
	assign empty     = (pend_q == 5'd0);

endmodule
